// File: sv/rti_pkg.sv
// Shared widths, codes and request/result types for the ray-triangle intersection unit.
package rti_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int UV_FRAC     = 30;
	localparam int UV_WIDTH    = UV_FRAC + 1;
	localparam int VERTEX_COUNT = 3;

	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int LO_W    = CROSS_W / 2;
	localparam int HI_W    = CROSS_W - LO_W;
	localparam int DOT_W   = DIFF_W + CROSS_W + 2;
	localparam int CHUNK_W = (DOT_W + 2) / 3;
	localparam int QUO_W   = (COORD_WIDTH > UV_WIDTH) ? COORD_WIDTH : UV_WIDTH;
	localparam int NUM_W   = DOT_W + QUO_W;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_RAY  = 1'b1
	} command_t;

	typedef struct packed {
		command_t                       command;
		logic [1:0]                     vertex_index;
		logic signed [COORD_WIDTH-1:0]  pos_x;
		logic signed [COORD_WIDTH-1:0]  pos_y;
		logic signed [COORD_WIDTH-1:0]  pos_z;
		logic signed [COORD_WIDTH-1:0]  dir_x;
		logic signed [COORD_WIDTH-1:0]  dir_y;
		logic signed [COORD_WIDTH-1:0]  dir_z;
		logic signed [COORD_WIDTH-1:0]  near_limit;
		logic signed [COORD_WIDTH-1:0]  far_limit;
	} request_t;

	typedef struct packed {
		logic                           hit_flag;
		logic signed [COORD_WIDTH-1:0]  distance;
		logic [UV_WIDTH-1:0]            bary_u;
		logic [UV_WIDTH-1:0]            bary_v;
	} result_t;

	// one item inside the division pipeline
	typedef struct packed {
		logic                           hit;
		logic signed [COORD_WIDTH-1:0]  near;
		logic [DOT_W-1:0]               a;
		logic [NUM_W-1:0]               n_t;
		logic [NUM_W-1:0]               n_u;
		logic [NUM_W-1:0]               n_v;
		logic [QUO_W-1:0]               q_t;
		logic [QUO_W-1:0]               q_u;
		logic [QUO_W-1:0]               q_v;
	} div_t;

endpackage

// File: sv/rti_div.sv
// Restoring division pipeline, one quotient bit per stage, three lanes sharing one divisor.
module rti_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         din_valid,
	input  rti_pkg::div_t din,
	output logic         dout_valid,
	output rti_pkg::div_t dout
);
	import rti_pkg::*;

	logic vld_s [QUO_W];
	div_t div_s [QUO_W];
	div_t nxt   [QUO_W];

	function automatic div_t div_step(div_t d, int sh);
		logic [NUM_W-1:0] dv;
		logic ge_t, ge_u, ge_v;
		div_t r;
		dv   = NUM_W'(d.a) << sh;
		ge_t = d.n_t >= dv;
		ge_u = d.n_u >= dv;
		ge_v = d.n_v >= dv;
		r     = d;
		r.n_t = ge_t ? d.n_t - dv : d.n_t;
		r.n_u = ge_u ? d.n_u - dv : d.n_u;
		r.n_v = ge_v ? d.n_v - dv : d.n_v;
		r.q_t = {d.q_t[QUO_W-2:0], ge_t};
		r.q_u = {d.q_u[QUO_W-2:0], ge_u};
		r.q_v = {d.q_v[QUO_W-2:0], ge_v};
		return r;
	endfunction

	always_comb begin
		nxt[0] = div_step(din, QUO_W - 1);
		for (int k = 1; k < QUO_W; k++) begin
			nxt[k] = div_step(div_s[k-1], QUO_W - 1 - k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= din_valid;
			for (int k = 1; k < QUO_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) div_s[k] <= nxt[k];
		end
	end

	assign dout_valid = vld_s[QUO_W-1];
	assign dout       = div_s[QUO_W-1];

endmodule

// File: sv/ray_triangle_intersection.sv
// Top level of the ray-triangle intersection unit.
// Moller-Trumbore test in signed Q16.16 with exact wide intermediates. A load request writes
// the vertex that its index names (index 3 writes none) and yields no result; the vertex
// store is zero after reset. A ray request yields one result after passing ten arithmetic
// stages (edges, cross products, split dot products, sign fix, interval products, numerators),
// a 32-stage restoring divider producing one quotient bit per stage for t, u and v together,
// and the output register. One request is accepted per cycle; the whole pipeline holds while
// a result waits at the output. Misses, including a zero determinant, return all zeros.
module ray_triangle_intersection (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                request_valid,
	output logic                request_ready,
	input  rti_pkg::request_t   request,
	output logic                result_valid,
	input  logic                result_ready,
	output rti_pkg::result_t    result
);
	import rti_pkg::*;

	localparam int NX1 [3] = '{1, 2, 0};
	localparam int NX2 [3] = '{2, 0, 1};

	logic en, acc;
	logic signed [COORD_WIDTH-1:0] pos [3];
	logic signed [COORD_WIDTH-1:0] dir [3];
	logic signed [COORD_WIDTH-1:0] vtx_q [VERTEX_COUNT][3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic res_vld_q;
	result_t res_q;

	// stage 1: edges
	logic signed [DIFF_W-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3], d_s1 [3];
	logic signed [COORD_WIDTH-1:0] near_s1, far_s1;
	// stage 2: cross product terms
	logic signed [PROD_W-1:0] hp_s2 [3], hm_s2 [3], qp_s2 [3], qm_s2 [3];
	logic signed [DIFF_W-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3], d_s2 [3];
	logic signed [COORD_WIDTH-1:0] near_s2, far_s2;
	// stage 3: cross products
	logic signed [CROSS_W-1:0] h_s3 [3], q_s3 [3];
	logic signed [DIFF_W-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3], d_s3 [3];
	logic signed [COORD_WIDTH-1:0] near_s3, far_s3;
	// stage 4: dot partial products (a, nu, nv, nt)
	logic signed [DIFF_W+HI_W-1:0]   phi_s4 [4][3];
	logic signed [DIFF_W+LO_W:0]     plo_s4 [4][3];
	logic signed [COORD_WIDTH-1:0] near_s4, far_s4;
	// stage 5: dot terms
	logic signed [DOT_W-1:0] term_s5 [4][3];
	logic signed [COORD_WIDTH-1:0] near_s5, far_s5;
	// stage 6: dots
	logic signed [DOT_W-1:0] dot_s6 [4];
	logic signed [COORD_WIDTH-1:0] near_s6, far_s6;
	// stage 7: sign fixed
	logic signed [DOT_W-1:0] a_s7, nu_s7, nv_s7, nt_s7;
	logic zero_s7;
	logic signed [COORD_WIDTH-1:0] near_s7, far_s7;
	// stage 8: barycentric check, limit partial products
	logic signed [DOT_W-1:0] a_s8, nu_s8, nv_s8, nt_s8;
	logic ok_s8;
	logic signed [COORD_WIDTH+CHUNK_W:0] lo_lim_s8 [3], hi_lim_s8 [3];
	logic signed [COORD_WIDTH-1:0] near_s8;
	// stage 9: limits times a
	logic signed [DOT_W-1:0] a_s9, nu_s9, nv_s9, nt_s9;
	logic ok_s9;
	logic signed [NUM_W-1:0] near_a_s9, far_a_s9;
	logic signed [COORD_WIDTH-1:0] near_s9;
	// stage 10: divider input
	div_t div_s10;

	logic signed [DIFF_W-1:0] xs [4][3];
	logic signed [CROSS_W-1:0] ys [4][3];
	logic [3*CHUNK_W-1:0] a_pad;
	logic uv_ok;
	logic signed [NUM_W-1:0] tn;
	logic div_vld;
	div_t div_out;

	assign en            = !res_vld_q || result_ready;
	assign request_ready = en;
	assign acc           = request_valid && request_ready;

	always_comb begin
		pos[0] = request.pos_x;
		pos[1] = request.pos_y;
		pos[2] = request.pos_z;
		dir[0] = request.dir_x;
		dir[1] = request.dir_y;
		dir[2] = request.dir_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VERTEX_COUNT; k++)
				for (int c = 0; c < 3; c++) vtx_q[k][c] <= '0;
		end else if (acc && request.command == CMD_LOAD) begin
			for (int k = 0; k < VERTEX_COUNT; k++)
				if (request.vertex_index == 2'(k))
					for (int c = 0; c < 3; c++) vtx_q[k][c] <= pos[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0; vld_s5 <= 1'b0;
			vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0; vld_s9 <= 1'b0; vld_s10 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= acc && request.command == CMD_RAY;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
			res_vld_q <= div_vld;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			xs[0][c] = e1_s3[c]; ys[0][c] = h_s3[c];
			xs[1][c] = s_s3[c];  ys[1][c] = h_s3[c];
			xs[2][c] = d_s3[c];  ys[2][c] = q_s3[c];
			xs[3][c] = e2_s3[c]; ys[3][c] = q_s3[c];
		end
		a_pad = (3*CHUNK_W)'(a_s7);
		uv_ok = !nu_s7[DOT_W-1] && nu_s7 <= a_s7 && !nv_s7[DOT_W-1]
			&& ((DOT_W+1)'(nu_s7) + (DOT_W+1)'(nv_s7)) <= (DOT_W+1)'(a_s7);
		tn = NUM_W'(nt_s9) <<< FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			for (int c = 0; c < 3; c++) begin
				e1_s1[c] <= DIFF_W'(vtx_q[1][c]) - DIFF_W'(vtx_q[0][c]);
				e2_s1[c] <= DIFF_W'(vtx_q[2][c]) - DIFF_W'(vtx_q[0][c]);
				s_s1[c]  <= DIFF_W'(pos[c]) - DIFF_W'(vtx_q[0][c]);
				d_s1[c]  <= DIFF_W'(dir[c]);
			end
			near_s1 <= request.near_limit;
			far_s1  <= request.far_limit;
			// stage 2
			for (int c = 0; c < 3; c++) begin
				hp_s2[c] <= d_s1[NX1[c]] * e2_s1[NX2[c]];
				hm_s2[c] <= d_s1[NX2[c]] * e2_s1[NX1[c]];
				qp_s2[c] <= s_s1[NX1[c]] * e1_s1[NX2[c]];
				qm_s2[c] <= s_s1[NX2[c]] * e1_s1[NX1[c]];
			end
			e1_s2 <= e1_s1; e2_s2 <= e2_s1; s_s2 <= s_s1; d_s2 <= d_s1;
			near_s2 <= near_s1; far_s2 <= far_s1;
			// stage 3
			for (int c = 0; c < 3; c++) begin
				h_s3[c] <= CROSS_W'(hp_s2[c]) - CROSS_W'(hm_s2[c]);
				q_s3[c] <= CROSS_W'(qp_s2[c]) - CROSS_W'(qm_s2[c]);
			end
			e1_s3 <= e1_s2; e2_s3 <= e2_s2; s_s3 <= s_s2; d_s3 <= d_s2;
			near_s3 <= near_s2; far_s3 <= far_s2;
			// stage 4
			for (int j = 0; j < 4; j++)
				for (int c = 0; c < 3; c++) begin
					phi_s4[j][c] <= xs[j][c] * $signed(ys[j][c][CROSS_W-1:LO_W]);
					plo_s4[j][c] <= xs[j][c] * $signed({1'b0, ys[j][c][LO_W-1:0]});
				end
			near_s4 <= near_s3; far_s4 <= far_s3;
			// stage 5
			for (int j = 0; j < 4; j++)
				for (int c = 0; c < 3; c++)
					term_s5[j][c] <= (DOT_W'(phi_s4[j][c]) <<< LO_W) + DOT_W'(plo_s4[j][c]);
			near_s5 <= near_s4; far_s5 <= far_s4;
			// stage 6
			for (int j = 0; j < 4; j++)
				dot_s6[j] <= term_s5[j][0] + term_s5[j][1] + term_s5[j][2];
			near_s6 <= near_s5; far_s6 <= far_s5;
			// stage 7: make the determinant positive
			zero_s7 <= dot_s6[0] == '0;
			a_s7  <= dot_s6[0][DOT_W-1] ? -dot_s6[0] : dot_s6[0];
			nu_s7 <= dot_s6[0][DOT_W-1] ? -dot_s6[1] : dot_s6[1];
			nv_s7 <= dot_s6[0][DOT_W-1] ? -dot_s6[2] : dot_s6[2];
			nt_s7 <= dot_s6[0][DOT_W-1] ? -dot_s6[3] : dot_s6[3];
			near_s7 <= near_s6; far_s7 <= far_s6;
			// stage 8
			ok_s8 <= !zero_s7 && uv_ok;
			for (int k = 0; k < 3; k++) begin
				lo_lim_s8[k] <= near_s7 * $signed({1'b0, a_pad[k*CHUNK_W +: CHUNK_W]});
				hi_lim_s8[k] <= far_s7 * $signed({1'b0, a_pad[k*CHUNK_W +: CHUNK_W]});
			end
			a_s8 <= a_s7; nu_s8 <= nu_s7; nv_s8 <= nv_s7; nt_s8 <= nt_s7;
			near_s8 <= near_s7;
			// stage 9
			near_a_s9 <= NUM_W'(lo_lim_s8[0]) + (NUM_W'(lo_lim_s8[1]) <<< CHUNK_W)
				+ (NUM_W'(lo_lim_s8[2]) <<< (2*CHUNK_W));
			far_a_s9 <= NUM_W'(hi_lim_s8[0]) + (NUM_W'(hi_lim_s8[1]) <<< CHUNK_W)
				+ (NUM_W'(hi_lim_s8[2]) <<< (2*CHUNK_W));
			a_s9 <= a_s8; nu_s9 <= nu_s8; nv_s9 <= nv_s8; nt_s9 <= nt_s8;
			ok_s9 <= ok_s8; near_s9 <= near_s8;
			// stage 10: numerators, t offset by near so its quotient is unsigned
			div_s10.hit  <= ok_s9 && tn >= near_a_s9 && tn <= far_a_s9;
			div_s10.near <= near_s9;
			div_s10.a    <= a_s9;
			div_s10.n_t  <= tn - near_a_s9;
			div_s10.n_u  <= NUM_W'(nu_s9) << UV_FRAC;
			div_s10.n_v  <= NUM_W'(nv_s9) << UV_FRAC;
			div_s10.q_t  <= '0;
			div_s10.q_u  <= '0;
			div_s10.q_v  <= '0;
			// output
			res_q.hit_flag <= div_out.hit;
			res_q.distance <= div_out.hit
				? div_out.near + $signed(div_out.q_t[COORD_WIDTH-1:0]) : '0;
			res_q.bary_u   <= div_out.hit ? div_out.q_u[UV_WIDTH-1:0] : '0;
			res_q.bary_v   <= div_out.hit ? div_out.q_v[UV_WIDTH-1:0] : '0;
		end
	end

	rti_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.din_valid  (vld_s10),
		.din        (div_s10),
		.dout_valid (div_vld),
		.dout       (div_out)
	);

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// File: sv/rti_checker.sv
// Port-level checks for the ray-triangle intersection unit, bound to the top level.
module rti_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              request_valid,
	input logic              request_ready,
	input rti_pkg::request_t request,
	input logic              result_valid,
	input logic              result_ready,
	input rti_pkg::result_t  result
);
	import rti_pkg::*;

	localparam logic [UV_WIDTH-1:0] UV_ONE = UV_WIDTH'(1) << UV_FRAC;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		request_valid && !request_ready |=> request_valid && $stable(request))
		else $error("request dropped or changed while stalled");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !request_ready)
		else $error("request taken while output is blocked");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit_flag |->
		result.distance == '0 && result.bary_u == '0 && result.bary_v == '0)
		else $error("miss carries nonzero fields");

	a_bary: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit_flag |->
		(UV_WIDTH+1)'(result.bary_u) + (UV_WIDTH+1)'(result.bary_v) <= (UV_WIDTH+1)'(UV_ONE))
		else $error("barycentric weights out of range");

endmodule

bind ray_triangle_intersection rti_checker u_rti_checker (.*);

// File: test/ray_triangle_intersection_test.sv
// Testbench for the ray-triangle intersection unit: scoreboard-checked random and directed requests.
module ray_triangle_intersection_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rti_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	class intersect_scoreboard;
		logic signed [COORD_WIDTH-1:0] verts [9];
		result_t pending [$];
		int errors;

		function new();
			foreach (verts[i]) verts[i] = '0;
			errors = 0;
		endfunction

		// exact Moller-Trumbore; 256-bit signed intermediates
		function automatic result_t compute_hit(request_t r);
			result_t res;
			logic signed [255:0] e1 [3], e2 [3], s [3], d [3], h [3], q [3];
			logic signed [255:0] a, nu, nv, nt, tn;
			res = '0;
			for (int c = 0; c < 3; c++) begin
				e1[c] = 256'(verts[3+c]) - 256'(verts[c]);
				e2[c] = 256'(verts[6+c]) - 256'(verts[c]);
				s[c] = 256'(r.pos_x) - 256'(verts[c]);
				if (c == 1) s[c] = 256'(r.pos_y) - 256'(verts[c]);
				if (c == 2) s[c] = 256'(r.pos_z) - 256'(verts[c]);
			end
			d[0] = 256'(r.dir_x); d[1] = 256'(r.dir_y); d[2] = 256'(r.dir_z);
			h[0] = d[1]*e2[2] - d[2]*e2[1];
			h[1] = d[2]*e2[0] - d[0]*e2[2];
			h[2] = d[0]*e2[1] - d[1]*e2[0];
			q[0] = s[1]*e1[2] - s[2]*e1[1];
			q[1] = s[2]*e1[0] - s[0]*e1[2];
			q[2] = s[0]*e1[1] - s[1]*e1[0];
			a = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
			nu = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
			nv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
			nt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
			if (a == 0) return res;
			if (a < 0) begin
				a = -a; nu = -nu; nv = -nv; nt = -nt;
			end
			if (nu < 0 || nu > a) return res;
			if (nv < 0 || nu + nv > a) return res;
			tn = nt <<< FRAC_BITS;
			if (tn < 256'(r.near_limit) * a) return res;
			if (tn > 256'(r.far_limit) * a) return res;
			res.hit_flag = 1'b1;
			res.distance = COORD_WIDTH'(floor_div(tn, a));
			res.bary_u = UV_WIDTH'(floor_div(nu <<< UV_FRAC, a));
			res.bary_v = UV_WIDTH'(floor_div(nv <<< UV_FRAC, a));
			return res;
		endfunction

		function automatic logic signed [255:0] floor_div(logic signed [255:0] n,
				logic signed [255:0] dv);
			logic signed [255:0] quo;
			quo = n / dv;
			if (n < 0 && quo * dv != n) quo = quo - 1;
			return quo;
		endfunction

		function void note_request(request_t r);
			if (r.command == CMD_LOAD) begin
				if (r.vertex_index != 2'd3) begin
					verts[3*r.vertex_index] = r.pos_x;
					verts[3*r.vertex_index+1] = r.pos_y;
					verts[3*r.vertex_index+2] = r.pos_z;
				end
			end else
				pending.push_back(compute_hit(r));
		endfunction

		function void check_result(result_t got);
			result_t exp_res;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (got.hit_flag !== exp_res.hit_flag) begin
				$display("%0t: hit_flag exp %b got %b", $time, exp_res.hit_flag, got.hit_flag);
				errors++;
			end
			if (got.distance !== exp_res.distance) begin
				$display("%0t: distance exp %h got %h", $time, exp_res.distance, got.distance);
				errors++;
			end
			if (got.bary_u !== exp_res.bary_u) begin
				$display("%0t: bary_u exp %h got %h", $time, exp_res.bary_u, got.bary_u);
				errors++;
			end
			if (got.bary_v !== exp_res.bary_v) begin
				$display("%0t: bary_v exp %h got %h", $time, exp_res.bary_v, got.bary_v);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic request_valid, request_ready, result_valid, result_ready;
	request_t request;
	result_t result;
	intersect_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	bit hold_off;
	longint cycles;

	ray_triangle_intersection dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(result);
		if (arst_n && request_valid && request_ready) sb.note_request(request);
	end

	always @(posedge clk) begin
		if (!arst_n || hold_off) result_ready <= 1'b0;
		else result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(20)) * ONE - 10 * ONE;
			2: return $signed(32'($urandom_range(1 << 20))) - (1 << 19);
			default: return $signed(32'($urandom_range(5))) - 2;
		endcase
	endfunction

	// valid stays high between back-to-back requests; it drops only on idle or drain
	task automatic send(request_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			request_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		request_valid <= 1'b1;
		request <= r;
		do @(posedge clk); while (!request_ready);
	endtask

	task automatic load_vertex(int k, logic signed [31:0] x, y, z);
		request_t r;
		r = '0;
		r.command = CMD_LOAD;
		r.vertex_index = 2'(k);
		r.pos_x = x; r.pos_y = y; r.pos_z = z;
		r.dir_x = $urandom; r.dir_y = $urandom; r.dir_z = $urandom;
		r.near_limit = $urandom; r.far_limit = $urandom;
		send(r);
	endtask

	task automatic cast_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz, lo, hi);
		request_t r;
		r.command = CMD_RAY;
		r.vertex_index = 2'($urandom_range(3));
		r.pos_x = ox; r.pos_y = oy; r.pos_z = oz;
		r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
		r.near_limit = lo; r.far_limit = hi;
		send(r);
	endtask

	task automatic wait_drained();
		request_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			int sel;
			sel = $urandom_range(99);
			if (sel < 8) begin
				for (int k = 0; k < 3; k++)
					load_vertex(k, rand_coord(), rand_coord(), rand_coord());
			end else if (sel < 10) begin
				load_vertex(3, $urandom, $urandom, $urandom);
			end else if (sel < 70) begin
				// aim at a point inside the unit triangle from above
				logic signed [31:0] px, py;
				px = $signed(32'($urandom_range(ONE)));
				py = $signed(32'($urandom_range(ONE - px)));
				cast_ray(px, py, 5 * ONE, $signed(32'($urandom_range(100))) - 50,
					$signed(32'($urandom_range(100))) - 50, -ONE,
					$urandom_range(1) ? -32'sd1 : 32'sh7FFF_FFFF - $urandom_range(9) * ONE,
					$urandom_range(1) ? 32'sh7FFF_FFFF : $signed(32'($urandom_range(8))) * ONE);
			end else
				cast_ray($urandom, $urandom, $urandom, rand_coord(), rand_coord(),
					rand_coord(), $urandom, $urandom);
			if (sel >= 70 && sel < 73) begin
				load_vertex(0, 0, 0, 0);
				load_vertex(1, ONE, 0, 0);
				load_vertex(2, 0, ONE, 0);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		request_valid = 1'b0;
		request = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero triangle after reset: degenerate
		cast_ray(0, 0, ONE, 0, 0, -ONE, 32'sh8000_0000, 32'sh7FFF_FFFF);
		load_vertex(0, 0, 0, 0);
		load_vertex(1, ONE, 0, 0);
		load_vertex(2, 0, ONE, 0);
		load_vertex(3, 32'sh7FFF_FFFF, 32'sh8000_0000, -1);
		cast_ray(ONE/4, ONE/4, ONE, 0, 0, -ONE, 0, 2 * ONE);
		cast_ray(0, 0, ONE, 0, 0, -ONE, ONE, ONE);
		cast_ray(ONE, 0, ONE, 0, 0, -ONE, 0, ONE);
		cast_ray(0, ONE, ONE, 0, 0, -ONE, ONE, ONE);
		cast_ray(ONE/2, ONE/2, ONE, 0, 0, -ONE, 0, ONE);
		cast_ray(ONE/2, ONE/2, ONE, 0, 0, ONE, 32'sh8000_0000, 32'sh7FFF_FFFF);
		cast_ray(0, 0, ONE, ONE, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		cast_ray(ONE/4, ONE/4, ONE, 0, 0, -ONE, ONE + 1, 2 * ONE);
		cast_ray(ONE/4, ONE/4, ONE, 0, 0, -ONE, 0, ONE - 1);
		cast_ray(2 * ONE, 0, ONE, 0, 0, -ONE, 0, 2 * ONE);
		cast_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		cast_ray(ONE/3, ONE/3, 1, 0, 0, -32'sd3, 32'sh8000_0000, 32'sh7FFF_FFFF);
		load_vertex(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		load_vertex(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		load_vertex(2, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		cast_ray(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF);
		cast_ray(0, 0, 0, -1, -1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF);
		wait_drained();

		load_vertex(0, 0, 0, 0);
		load_vertex(1, ONE, 0, 0);
		load_vertex(2, 0, ONE, 0);
		random_phase(200);
		send_idle_pct = 87;
		random_phase(160);
		send_idle_pct = 0;
		recv_stall_pct = 87;
		random_phase(160);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		random_phase(160);

		// long receiver hold-off with a full-rate sender
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(130);
		join
		wait_drained();
		random_phase(85);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: sim.f
sv/rti_pkg.sv
sv/rti_div.sv
sv/ray_triangle_intersection.sv
sv/rti_checker.sv
test/ray_triangle_intersection_test.sv
